[rtl/mrt_pkg.sv]
// Shared types, codes and constants of the memory region table.
package mrt_pkg;

    // Default number of table entries.
    localparam int MAX_ENTRIES_DEF = 32;

    // Fixed field widths.
    localparam int WORD_W        = 32;
    localparam int LEN_W         = 33;
    localparam int ENTRY_COUNT_W = 6;

    typedef logic [WORD_W-1:0]        t_word;
    typedef logic [LEN_W-1:0]         t_len;
    typedef logic [1:0]               t_op;
    typedef logic [1:0]               t_status;
    typedef logic [ENTRY_COUNT_W-1:0] t_entry_count;

    // Operation codes.
    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_ADD    = 2'd1;
    localparam t_op OP_LOOKUP = 2'd2;

    // Status codes.
    localparam t_status STAT_DONE = 2'd0;
    localparam t_status STAT_HIGH = 2'd1;
    localparam t_status STAT_FULL = 2'd2;

    // 4 GiB as a 33-bit value, and the saturation limit of the free total.
    localparam t_len FOUR_GIB = {1'b1, {WORD_W{1'b0}}};
    localparam t_len SUM_MAX  = {LEN_W{1'b1}};

    // Reset value of the free kind register.
    localparam t_word FREE_KIND_RST = 32'd1;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // One stored table entry.
    typedef struct packed {
        t_word base;
        t_len  length;
        t_word kind;
    } t_entry;

    // Write command to one cell.
    typedef struct packed {
        logic   en;
        t_entry entry;
    } t_cell_wr;

    // Lookup token handed from cell to cell.
    typedef struct packed {
        logic  active;
        logic  hit;
        t_word probe;
        t_word kind;
    } t_token;

endpackage

[rtl/mrt_if.sv]
// Handshake channel interfaces of the memory region table.
interface mrt_in_if;
    logic             valid;
    logic             ready;
    mrt_pkg::t_op     op;
    mrt_pkg::t_word   base_low;
    mrt_pkg::t_word   base_high;
    mrt_pkg::t_word   length_low;
    mrt_pkg::t_word   length_high;
    mrt_pkg::t_word   entry_kind;
    mrt_pkg::t_word   probe_address;

    modport source (output valid, op, base_low, base_high, length_low, length_high,
                    entry_kind, probe_address, input ready);
    modport sink   (input valid, op, base_low, base_high, length_low, length_high,
                    entry_kind, probe_address, output ready);
endinterface

interface mrt_out_if;
    logic                  valid;
    logic                  ready;
    mrt_pkg::t_word        found_kind;
    mrt_pkg::t_len         free_total;
    mrt_pkg::t_entry_count entry_count;
    mrt_pkg::t_status      status;

    modport source (output valid, found_kind, free_total, entry_count, status,
                    input ready);
    modport sink   (input valid, found_kind, free_total, entry_count, status,
                    output ready);
endinterface

interface mrt_cfg_if;
    logic           valid;
    logic           ready;
    mrt_pkg::t_word free_kind;

    modport source (output valid, free_kind, input ready);
    modport sink   (input valid, free_kind, output ready);
endinterface

[rtl/mrt_cell.sv]
// One table cell: holds one entry and checks a passing lookup token against it.
module mrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrt_pkg::t_cell_wr i_wr,
    input  logic              i_entry_valid,
    input  mrt_pkg::t_token   i_tok,
    output mrt_pkg::t_token   o_tok
);
    import mrt_pkg::*;

    t_entry r_entry;
    t_token r_tok;
    t_token n_tok;
    t_word  offset;
    logic   covers;

    // Entry storage, written when this cell is the next free slot.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_entry <= i_wr.entry;
        end
    end

    // A zero-length entry covers nothing, since no offset is below zero.
    always_comb begin
        offset = i_tok.probe - r_entry.base;
        covers = i_entry_valid && (i_tok.probe >= r_entry.base)
                 && ({1'b0, offset} < r_entry.length);
    end

    // The first covering cell marks the token; later cells leave it alone.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.active && !i_tok.hit && covers) begin
            n_tok.hit  = 1'b1;
            n_tok.kind = r_entry.kind;
        end
    end

    // Token register toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= n_tok.active;
        end
        r_tok.hit   <= n_tok.hit;
        r_tok.probe <= n_tok.probe;
        r_tok.kind  <= n_tok.kind;
    end

    assign o_tok = r_tok;

endmodule

[rtl/memory_region_table_top.sv]
// Memory region table: a row of entry cells with a controller for clear, add and lookup.
// Clear, add and the unused op code show their result in the cycle after they are
// accepted. A lookup token walks the row of MAX_ENTRIES cells, one cell per cycle,
// through the token register of each cell, and the result is registered once the
// token leaves the last cell. The block takes one transaction at a time and accepts the
// next one once the result of the previous one has been taken, or in the cycle it is.
// Set free_kind before loading entries: it is applied when an entry is added.
module memory_region_table_top #(
    parameter int MAX_ENTRIES = mrt_pkg::MAX_ENTRIES_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    mrt_in_if.sink   i_in,
    mrt_cfg_if.sink  i_cfg,
    mrt_out_if.source o_out
);
    import mrt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    t_word            r_found;
    t_word            n_found;
    t_status          r_status;
    t_status          n_status;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_len             r_free_sum;
    t_len             n_free_sum;
    t_word            r_free_kind;

    logic             in_ready;
    logic             accept;
    logic             table_full;
    t_len             add_end;
    t_len             add_len;
    logic [LEN_W:0]   add_sum;
    t_cell_wr         wr_cmd;
    logic             add_commit;
    t_token           launch_tok;
    t_token           tok [MAX_ENTRIES+1];

    assign accept     = i_in.valid && in_ready;
    assign table_full = (r_count == CNT_W'(MAX_ENTRIES));

    // Configuration register; the port never stalls.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_kind <= FREE_KIND_RST;
        end else if (i_cfg.valid) begin
            r_free_kind <= i_cfg.free_kind;
        end
    end

    // Clipped length of an added entry and the saturating free total.
    always_comb begin
        add_end = {1'b0, i_in.base_low} + {1'b0, i_in.length_low};
        if ((i_in.length_high != '0) || (add_end > FOUR_GIB)) begin
            add_len = FOUR_GIB - {1'b0, i_in.base_low};
        end else begin
            add_len = {1'b0, i_in.length_low};
        end
        add_sum = {1'b0, r_free_sum} + {1'b0, add_len};
    end

    assign add_commit = accept && (i_in.op == OP_ADD) && (i_in.base_high == '0)
                        && !table_full;

    // Entry write command shared by all cells.
    always_comb begin
        wr_cmd.en           = add_commit;
        wr_cmd.entry.base   = i_in.base_low;
        wr_cmd.entry.length = add_len;
        wr_cmd.entry.kind   = i_in.entry_kind;
    end

    // Token launched into the first cell when a lookup is accepted.
    always_comb begin
        launch_tok.active = accept && (i_in.op == OP_LOOKUP);
        launch_tok.hit    = 1'b0;
        launch_tok.probe  = i_in.probe_address;
        launch_tok.kind   = '0;
    end
    assign tok[0] = launch_tok;

    // Row of entry cells.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_cell_wr cell_wr;
        always_comb begin
            cell_wr    = wr_cmd;
            cell_wr.en = wr_cmd.en && (r_count == CNT_W'(g));
        end
        mrt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_wr          (cell_wr),
            .i_entry_valid (CNT_W'(g) < r_count),
            .i_tok         (tok[g]),
            .o_tok         (tok[g+1])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_in.op == OP_LOOKUP)) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (tok[MAX_ENTRIES].active) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        unique case (r_state)
            ST_IDLE: in_ready = !r_out_valid || o_out.ready;
            ST_WALK: in_ready = 1'b0;
            default: in_ready = 1'b0;
        endcase
    end
    assign i_in.ready = in_ready;

    // Table state and result register updates.
    always_comb begin
        n_count     = r_count;
        n_free_sum  = r_free_sum;
        n_found     = r_found;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (tok[MAX_ENTRIES].active) begin
            n_found     = tok[MAX_ENTRIES].hit ? tok[MAX_ENTRIES].kind : '0;
            n_status    = STAT_DONE;
            n_out_valid = 1'b1;
        end
        if (accept) begin
            n_found  = '0;
            n_status = STAT_DONE;
            unique case (i_in.op)
                OP_CLEAR: begin
                    n_count     = '0;
                    n_free_sum  = '0;
                    n_out_valid = 1'b1;
                end
                OP_ADD: begin
                    n_out_valid = 1'b1;
                    if (i_in.base_high != '0) begin
                        n_status = STAT_HIGH;
                    end else if (table_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        if (i_in.entry_kind == r_free_kind) begin
                            n_free_sum = add_sum[LEN_W] ? SUM_MAX : add_sum[LEN_W-1:0];
                        end
                    end
                end
                OP_LOOKUP: begin
                    n_out_valid = 1'b0;
                end
                default: begin
                    n_out_valid = 1'b1;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_free_sum  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_free_sum  <= n_free_sum;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_found  <= n_found;
        r_status <= n_status;
    end

    // Result channel.
    assign o_out.valid       = r_out_valid;
    assign o_out.found_kind  = r_found;
    assign o_out.free_total  = r_free_sum;
    assign o_out.entry_count = ENTRY_COUNT_W'(r_count);
    assign o_out.status      = r_status;

endmodule
